// ----- hdl/mrft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrft_pkg;

  // default ring count
  localparam int NUM_RINGS_DEF = 8;

  // saturation limit of the outstanding count
  localparam logic [63:0] COUNT_CAP = 64'h0000_0000_1000_0000;

  // operation codes
  typedef enum logic [2:0] {
    OP_EMIT      = 3'd0,
    OP_PROCESS   = 3'd1,
    OP_SIGNALED  = 3'd2,
    OP_NEED_SYNC = 3'd3,
    OP_NOTE_SYNC = 3'd4,
    OP_COUNT     = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_EM,
    S_LD_EM,
    S_INC,
    S_SIG,
    S_P_HI,
    S_P_LO,
    S_P_EM,
    S_POST,
    S_CAP,
    S_RD_NEED,
    S_NEED,
    S_N_RA,
    S_N_RB,
    S_N_CMP,
    S_DONE
  } state_t;

  // shared adder modes
  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  // command transaction
  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  ring;
    logic [2:0]  other_ring;
    logic [63:0] sequence_req;
    logic [31:0] hw_value;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic        flag;
    logic [63:0] value;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/mrft_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/mrft_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrft_alu
  import mrft_pkg::*;
(
  input  wire logic [63:0] a,
  input  wire alu_op_t     op,
  input  wire logic [63:0] b,
  output logic      [63:0] res,
  output logic             borrow
);

  logic [63:0] b_eff;
  logic [64:0] sum;

  // one 64-bit adder: a - b for compares, a + 1 for increments
  always_comb begin
    b_eff  = (op == ALU_SUB) ? ~b : 64'd0;
    sum    = {1'b0, a} + {1'b0, b_eff} + 65'd1;
    res    = sum[63:0];
    borrow = (op == ALU_SUB) && !sum[64];
  end

endmodule

`default_nettype wire

// ----- hdl/mrft_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrft_store #(
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata
);

  localparam int DEPTH = 1 << AW;

  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  logic [63:0]      ram_rdata;

  mrft_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // per-entry valid bits, never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? ram_rdata : 64'd0;

endmodule

`default_nettype wire

// ----- hdl/multi_ring_fence_tracker_unit.sv -----
// sequencing: undefined or out-of-range commands go straight from idle to done; the other
//   operations step through their states on one adder and one registered RAM port
// note sync: steps through every source ring other than the destination
// one command at a time: busy stays high through the done cycle and the next start is
//   taken only once the sequencer is back in idle
// reset: synchronous active-high rst clears last-signaled registers and sync valid bits;
//   the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module multi_ring_fence_tracker_unit
  import mrft_pkg::*;
#(
  parameter int NUM_RINGS = NUM_RINGS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output res_t      result
);

  localparam int RING_W = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int SC_AW  = 2 * RING_W;

  state_t state, state_next;

  logic [2:0]        op;
  logic [RING_W-1:0] r_idx;
  logic [RING_W-1:0] d_idx;
  logic [RING_W-1:0] col;
  logic [63:0]       req;
  logic [31:0]       hw;
  logic [63:0]       emitted;
  logic [63:0]       cand;
  logic              pflag;
  logic              flag;
  logic [63:0]       value;
  logic [63:0]       ls [NUM_RINGS];

  logic [63:0]      last_cur;
  logic             r_ok, d_ok, same_ring, accept, col_last;
  logic [63:0]      alu_a, alu_b, alu_res;
  alu_op_t          alu_op;
  logic             alu_borrow;
  logic [SC_AW-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [63:0]      wr_data, sc_rdata;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign result    = '{flag: flag, value: value};
  assign last_cur  = ls[r_idx];
  assign col_last  = (col == RING_W'(NUM_RINGS - 1));
  assign r_ok      = {2'b00, cmd.ring} < 5'(NUM_RINGS);
  assign d_ok      = {2'b00, cmd.other_ring} < 5'(NUM_RINGS);
  assign same_ring = (cmd.ring == cmd.other_ring);

  mrft_alu u_alu (
    .a     (alu_a),
    .op    (alu_op),
    .b     (alu_b),
    .res   (alu_res),
    .borrow(alu_borrow)
  );

  mrft_store #(
    .AW(SC_AW)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .raddr(rd_addr),
    .rdata(sc_rdata),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.operation)
            OP_EMIT, OP_PROCESS, OP_SIGNALED, OP_COUNT:
              state_next = r_ok ? S_RD_EM : S_DONE;
            OP_NEED_SYNC:
              state_next = (r_ok && d_ok && !same_ring) ? S_RD_NEED : S_DONE;
            OP_NOTE_SYNC:
              state_next = (r_ok && d_ok && !same_ring) ? S_N_RA : S_DONE;
            default:
              state_next = S_DONE;
          endcase
        end
      end
      S_RD_EM: state_next = S_LD_EM;
      S_LD_EM: begin
        case (op)
          OP_EMIT:     state_next = S_INC;
          OP_SIGNALED: state_next = S_SIG;
          default:     state_next = S_P_HI;
        endcase
      end
      S_INC:     state_next = S_DONE;
      S_SIG:     state_next = alu_borrow ? S_P_HI : S_DONE;
      S_P_HI:    state_next = S_P_LO;
      S_P_LO:    state_next = alu_borrow ? S_P_EM : S_POST;
      S_P_EM:    state_next = S_POST;
      S_POST:    state_next = (op == OP_COUNT) ? S_CAP : S_DONE;
      S_CAP:     state_next = S_DONE;
      S_RD_NEED: state_next = S_NEED;
      S_NEED:    state_next = S_DONE;
      S_N_RA: begin
        if (col == d_idx) begin
          state_next = col_last ? S_DONE : S_N_RA;
        end else begin
          state_next = S_N_RB;
        end
      end
      S_N_RB:  state_next = S_N_CMP;
      S_N_CMP: state_next = col_last ? S_DONE : S_N_RA;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // adder operands and store port control
  always_comb begin
    alu_a   = emitted;
    alu_b   = cand;
    alu_op  = ALU_SUB;
    rd_addr = {r_idx, r_idx};
    wr_en   = 1'b0;
    wr_addr = {r_idx, r_idx};
    wr_data = alu_res;
    case (state)
      S_INC: begin
        alu_op = ALU_INC;
        wr_en  = 1'b1;
      end
      S_SIG: begin
        alu_a = last_cur;
        alu_b = req;
      end
      S_P_HI: begin
        alu_a = {last_cur[63:32], hw};
        alu_b = last_cur;
      end
      S_P_LO: begin
        alu_a = last_cur;
        alu_b = cand;
      end
      S_POST: begin
        if (op == OP_COUNT) begin
          alu_a = emitted;
          alu_b = last_cur;
        end else begin
          alu_a = last_cur;
          alu_b = req;
        end
      end
      S_CAP: begin
        alu_a = COUNT_CAP;
        alu_b = cand;
      end
      S_RD_NEED: rd_addr = {d_idx, r_idx};
      S_NEED: begin
        alu_a = sc_rdata;
        alu_b = req;
      end
      S_N_RA: rd_addr = {r_idx, col};
      S_N_RB: rd_addr = {d_idx, col};
      S_N_CMP: begin
        alu_a   = sc_rdata;
        alu_b   = cand;
        wr_en   = alu_borrow;
        wr_addr = {d_idx, col};
        wr_data = cand;
      end
      default: begin
      end
    endcase
  end

  // state register and per-ring last-signaled values
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_RINGS; i++) begin
        ls[i] <= 64'd0;
      end
    end else begin
      state <= state_next;
      if (state == S_P_EM && !alu_borrow) begin
        ls[r_idx] <= cand;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op    <= cmd.operation;
          r_idx <= RING_W'(cmd.ring);
          d_idx <= RING_W'(cmd.other_ring);
          req   <= cmd.sequence_req;
          hw    <= cmd.hw_value;
          col   <= '0;
          flag  <= 1'b0;
          value <= 64'd0;
        end
      end
      S_LD_EM: begin
        emitted <= sc_rdata;
        pflag   <= 1'b0;
      end
      S_INC: value <= alu_res;
      S_SIG: begin
        if (!alu_borrow) begin
          flag  <= 1'b1;
          value <= last_cur;
        end
      end
      // widen the hardware value against last or emitted upper half
      S_P_HI: cand <= alu_borrow ? {emitted[63:32], hw} : {last_cur[63:32], hw};
      S_P_EM: begin
        if (!alu_borrow) begin
          pflag <= 1'b1;
        end
      end
      S_POST: begin
        case (op)
          OP_PROCESS: begin
            flag  <= pflag;
            value <= last_cur;
          end
          OP_SIGNALED: begin
            flag  <= !alu_borrow;
            value <= last_cur;
          end
          default: cand <= alu_res;
        endcase
      end
      S_CAP:  value <= alu_borrow ? COUNT_CAP : cand;
      S_NEED: flag <= alu_borrow;
      S_N_RA: begin
        if (col == d_idx) begin
          col <= col + 1'b1;
        end
      end
      S_N_RB:  cand <= sc_rdata;
      S_N_CMP: col <= col + 1'b1;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mrft_pkg::*;

  // codes outside the defined operation set
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int RINGS = NUM_RINGS_DEF;
  localparam int ITEMS_PER_PHASE = 610;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES = 40;

  // fence tracker model and store of awaited results
  class fence_scoreboard;
    logic [63:0] ring_last[RINGS];
    logic [63:0] ring_sync[RINGS][RINGS];
    res_t awaited_results[$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < RINGS; i++) begin
        ring_last[i] = '0;
        for (int j = 0; j < RINGS; j++) ring_sync[i][j] = '0;
      end
    endfunction

    // extend a 32-bit hardware value and take it if it is in (last, emitted]
    function bit poll_fence(int r, logic [31:0] hw);
      logic [63:0] last;
      logic [63:0] emitted;
      logic [63:0] cand;
      last = ring_last[r];
      emitted = ring_sync[r][r];
      cand = {last[63:32], hw};
      if (cand < last) cand = {emitted[63:32], hw};
      if (cand <= last || cand > emitted) return 1'b0;
      ring_last[r] = cand;
      return 1'b1;
    endfunction

    // predict the result of an accepted command transaction
    function void accept_cmd(cmd_t c);
      res_t exp_res;
      int r;
      int d;
      bit r_ok;
      bit d_ok;
      logic [63:0] diff;
      exp_res = '0;
      r = c.ring;
      d = c.other_ring;
      r_ok = r < RINGS;
      d_ok = d < RINGS;
      case (c.operation)
        OP_EMIT: begin
          if (r_ok) begin
            ring_sync[r][r] = ring_sync[r][r] + 64'd1;
            exp_res.value = ring_sync[r][r];
          end
        end
        OP_PROCESS: begin
          if (r_ok) begin
            exp_res.flag = poll_fence(r, c.hw_value);
            exp_res.value = ring_last[r];
          end
        end
        OP_SIGNALED: begin
          if (r_ok) begin
            if (ring_last[r] >= c.sequence_req) begin
              exp_res.flag = 1'b1;
            end else begin
              void'(poll_fence(r, c.hw_value));
              exp_res.flag = ring_last[r] >= c.sequence_req;
            end
            exp_res.value = ring_last[r];
          end
        end
        OP_NEED_SYNC: begin
          if (r_ok && d_ok && r != d) exp_res.flag = c.sequence_req > ring_sync[d][r];
        end
        OP_NOTE_SYNC: begin
          if (r_ok && d_ok && r != d) begin
            for (int i = 0; i < RINGS; i++) begin
              if (i != d && ring_sync[r][i] > ring_sync[d][i]) ring_sync[d][i] = ring_sync[r][i];
            end
          end
        end
        OP_COUNT: begin
          if (r_ok) begin
            void'(poll_fence(r, c.hw_value));
            diff = ring_sync[r][r] - ring_last[r];
            exp_res.value = (diff > COUNT_CAP) ? COUNT_CAP : diff;
          end
        end
        default: begin
        end
      endcase
      awaited_results.push_back(exp_res);
    endfunction

    // compare a result transaction with the oldest awaited one
    function void check_result(res_t got);
      res_t exp_res;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: flag %0b value %h", got.flag, got.value);
        errors++;
        return;
      end
      exp_res = awaited_results.pop_front();
      if (got.flag !== exp_res.flag) begin
        $error("flag mismatch: expected %0b actual %0b", exp_res.flag, got.flag);
        errors++;
      end
      if (got.value !== exp_res.value) begin
        $error("value mismatch: expected %h actual %h", exp_res.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  res_t result;
  int cycles = 0;
  fence_scoreboard sb = new();

  multi_ring_fence_tracker_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [2:0] r, logic [2:0] d,
                                    logic [63:0] req, logic [31:0] hw);
    cmd_t c;
    c.operation = op;
    c.ring = r;
    c.other_ring = d;
    c.sequence_req = req;
    c.hw_value = hw;
    return c;
  endfunction

  // random command, mostly aimed near the current fence state of the ring
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    logic [63:0] last;
    logic [63:0] emitted;
    logic [63:0] base;
    logic [63:0] pick;
    c.ring = 3'($urandom_range(0, RINGS - 1));
    c.other_ring = ($urandom_range(0, 9) == 0) ? c.ring : 3'($urandom_range(0, RINGS - 1));
    sel = $urandom_range(0, 99);
    if (sel < 24) c.operation = OP_EMIT;
    else if (sel < 44) c.operation = OP_PROCESS;
    else if (sel < 60) c.operation = OP_SIGNALED;
    else if (sel < 70) c.operation = OP_COUNT;
    else if (sel < 80) c.operation = OP_NEED_SYNC;
    else if (sel < 93) c.operation = OP_NOTE_SYNC;
    else if (sel < 96) c.operation = OP_RSVD_6;
    else c.operation = OP_RSVD_7;
    last = sb.ring_last[c.ring];
    emitted = sb.ring_sync[c.ring][c.ring];
    // hardware value: near the window, at the emitted count, or anything
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      pick = last + 64'($urandom_range(0, 32'(emitted - last) + 3)) - 64'd1;
      c.hw_value = pick[31:0];
    end else if (sel < 70) begin
      c.hw_value = emitted[31:0];
    end else begin
      c.hw_value = $urandom;
    end
    // target sequence: near the compared count or anything
    if (c.operation == OP_NEED_SYNC) base = sb.ring_sync[c.other_ring][c.ring];
    else base = last;
    if ($urandom_range(0, 99) < 70) c.sequence_req = base + 64'($urandom_range(0, 6)) - 64'd3;
    else c.sequence_req = {$urandom, $urandom};
    return c;
  endfunction

  function automatic int pick_gap(int pct);
    int g;
    g = 0;
    while (g < 30 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // offer one command until accepted, then idle for gap cycles
  task automatic issue(cmd_t c, int gap);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.accept_cmd(c);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  // directed then random stimulus
  initial begin
    int idle_pct[3];
    int gap;
    bit pause;
    idle_pct[0] = 32;
    idle_pct[1] = 65;
    idle_pct[2] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring, emits, window edges, sync on same ring, reserved codes
    issue(make_cmd(OP_COUNT, 3'd0, 3'd0, '0, 32'h0), 0);
    issue(make_cmd(OP_PROCESS, 3'd0, 3'd0, '0, 32'hffff_ffff), 0);
    issue(make_cmd(OP_EMIT, 3'd0, 3'd0, '0, 32'h0), 0);
    issue(make_cmd(OP_EMIT, 3'd0, 3'd0, '1, 32'hffff_ffff), 2);
    issue(make_cmd(OP_EMIT, 3'd0, 3'd1, '0, 32'h0), 0);
    issue(make_cmd(OP_PROCESS, 3'd0, 3'd0, '0, 32'h1), 0);
    issue(make_cmd(OP_PROCESS, 3'd0, 3'd0, '0, 32'h1), 1);
    issue(make_cmd(OP_PROCESS, 3'd0, 3'd0, '0, 32'h4), 0);
    issue(make_cmd(OP_SIGNALED, 3'd0, 3'd0, '0, 32'h3), 0);
    issue(make_cmd(OP_SIGNALED, 3'd0, 3'd0, '1, 32'h3), 3);
    issue(make_cmd(OP_COUNT, 3'd0, 3'd0, '0, 32'h0), 0);
    issue(make_cmd(OP_EMIT, 3'd7, 3'd7, '0, 32'h0), 0);
    issue(make_cmd(OP_EMIT, 3'd7, 3'd0, '0, 32'h0), 0);
    issue(make_cmd(OP_PROCESS, 3'd7, 3'd7, '1, 32'hffff_ffff), 0);
    issue(make_cmd(OP_NEED_SYNC, 3'd0, 3'd7, 64'd3, 32'h0), 0);
    issue(make_cmd(OP_NEED_SYNC, 3'd0, 3'd0, '1, 32'hffff_ffff), 1);
    issue(make_cmd(OP_NOTE_SYNC, 3'd0, 3'd7, '0, 32'h0), 0);
    issue(make_cmd(OP_NEED_SYNC, 3'd0, 3'd7, 64'd3, 32'h0), 0);
    issue(make_cmd(OP_NOTE_SYNC, 3'd3, 3'd3, '1, 32'hffff_ffff), 0);
    issue(make_cmd(OP_NEED_SYNC, 3'd7, 3'd0, '1, 32'hffff_ffff), 0);
    issue(make_cmd(OP_RSVD_6, 3'd7, 3'd7, '1, 32'hffff_ffff), 0);
    issue(make_cmd(OP_RSVD_7, 3'd0, 3'd0, '0, 32'h0), 0);
    issue(make_cmd(OP_EMIT, 3'd7, 3'd7, '1, 32'hffff_ffff), 0);
    issue(make_cmd(OP_COUNT, 3'd7, 3'd7, '0, 32'h2), 1);
    wait_drain();

    // random phases with different sender idling, draining between them
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        gap = pick_gap(idle_pct[p]);
        pause = (i == ITEMS_PER_PHASE - 1) || (p == 0 && i == ITEMS_PER_PHASE / 2);
        if (pause && gap == 0) gap = 1;
        issue(rand_cmd(), gap);
        if (pause) wait_drain();
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
